### rtl/hfa_pkg.sv
// Package with the half-float field types, constants and leading-zero count of the adder.
package hfa_pkg;

    typedef logic [15:0] half_t;

    localparam logic [15:0] HfNan    = 16'h7C01;
    localparam logic [15:0] HfPosInf = 16'h7C00;
    localparam logic [15:0] HfNegInf = 16'hFC00;
    localparam logic [10:0] HfHidden = 11'd1024;
    localparam logic [4:0]  ExpMax   = 5'd31;

    // Number of leading zeros of an 11-bit significand, 11 for zero.
    function automatic logic [3:0] lzc11(input logic [10:0] v);
        logic [3:0] n;
        logic       found;
        n     = 4'd11;
        found = 1'b0;
        for (int i = 10; i >= 0; i--) begin
            if (!found && v[i]) begin
                n     = 4'(10 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

### rtl/hfa_if.sv
// Valid/ready channel interface carrying one payload word.
interface hfa_if #(
    parameter int Width = 16
) (
    input logic clk
);
    logic             valid;
    logic             ready;
    logic [Width-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/half_float_adder.sv
// Half-precision adder as a four-stage pipeline; alignment truncates the
// bits shifted out of the smaller significand. Four stages: operand sort
// and special-case decode, alignment shift, significand add or subtract,
// then normalization and packing. One word of two operands (operand_a in
// data[31:16], operand_b in data[15:0]) is taken every cycle while the
// output is not stalled; the sum passes through st1, st2, st3 and out_reg.
// A stall on the output holds the whole pipeline; bubbles are squeezed out.
module half_float_adder (
    input logic clk,
    input logic rst_n,
    hfa_if.sink   in_ch,
    hfa_if.source out_ch
);
    import hfa_pkg::*;

    localparam int Stages = 4;

    logic [Stages-1:0] vld_reg;
    logic [Stages-1:0] adv;

    // Stage enables: a stage moves when it is empty or the next one moves.
    always_comb
    begin
        adv[Stages-1] = !vld_reg[Stages-1] || out_ch.ready;
        for (int i = Stages - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign in_ch.ready  = adv[0];
    assign out_ch.valid = vld_reg[Stages-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_ch.valid;
            end
            for (int i = 1; i < Stages; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Stage 1: decode and sort.
    half_t       a, b, big, sml;
    logic        s1_special;
    half_t       s1_special_val;
    logic        a_nan, b_nan, a_inf, b_inf;

    assign a = in_ch.data[31:16];
    assign b = in_ch.data[15:0];

    always_comb
    begin
        a_nan = (a[14:10] == ExpMax) && (a[9:0] != '0);
        b_nan = (b[14:10] == ExpMax) && (b[9:0] != '0);
        a_inf = (a[14:10] == ExpMax) && (a[9:0] == '0);
        b_inf = (b[14:10] == ExpMax) && (b[9:0] == '0);
        s1_special     = a_nan || b_nan || a_inf || b_inf;
        s1_special_val = HfNan;
        if (!(a_nan || b_nan))
        begin
            if (a_inf && b_inf && (a[15] != b[15]))
            begin
                s1_special_val = HfNan;
            end
            else if (a_inf)
            begin
                s1_special_val = a[15] ? HfNegInf : HfPosInf;
            end
            else
            begin
                s1_special_val = b[15] ? HfNegInf : HfPosInf;
            end
        end
        if (a[14:0] >= b[14:0])
        begin
            big = a;
            sml = b;
        end
        else
        begin
            big = b;
            sml = a;
        end
    end

    logic        st1_special_reg, st1_sub_reg, st1_eq_reg, st1_sign_reg;
    half_t       st1_special_val_reg;
    logic [4:0]  st1_el_reg, st1_es_reg;
    logic [10:0] st1_ml_reg, st1_ms_reg;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            st1_special_reg     <= s1_special;
            st1_special_val_reg <= s1_special_val;
            st1_sub_reg         <= a[15] != b[15];
            st1_eq_reg          <= a[14:0] == b[14:0];
            st1_sign_reg        <= big[15];
            st1_el_reg          <= (big[14:10] == '0) ? 5'd1 : big[14:10];
            st1_es_reg          <= (sml[14:10] == '0) ? 5'd1 : sml[14:10];
            st1_ml_reg          <= {big[14:10] != '0, big[9:0]};
            st1_ms_reg          <= {sml[14:10] != '0, sml[9:0]};
        end
    end

    // Stage 2: align the smaller significand.
    logic [4:0] d2;
    assign d2 = st1_el_reg - st1_es_reg;

    logic        st2_special_reg, st2_sub_reg, st2_eq_reg, st2_sign_reg;
    half_t       st2_special_val_reg;
    logic [4:0]  st2_el_reg;
    logic [10:0] st2_ml_reg, st2_ms_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            st2_special_reg     <= st1_special_reg;
            st2_special_val_reg <= st1_special_val_reg;
            st2_sub_reg         <= st1_sub_reg;
            st2_eq_reg          <= st1_eq_reg;
            st2_sign_reg        <= st1_sign_reg;
            st2_el_reg          <= st1_el_reg;
            st2_ml_reg          <= st1_ml_reg;
            st2_ms_reg          <= st1_ms_reg >> d2;
        end
    end

    // Stage 3: add or subtract.
    logic        st3_special_reg, st3_sub_reg, st3_eq_reg, st3_sign_reg;
    half_t       st3_special_val_reg;
    logic [4:0]  st3_el_reg;
    logic [11:0] st3_sum_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            st3_special_reg     <= st2_special_reg;
            st3_special_val_reg <= st2_special_val_reg;
            st3_sub_reg         <= st2_sub_reg;
            st3_eq_reg          <= st2_eq_reg;
            st3_sign_reg        <= st2_sign_reg;
            st3_el_reg          <= st2_el_reg;
            st3_sum_reg         <= st2_sub_reg
                                   ? {1'b0, st2_ml_reg - st2_ms_reg}
                                   : {1'b0, st2_ml_reg} + {1'b0, st2_ms_reg};
        end
    end

    // Stage 4: normalize and pack.
    half_t      res;
    logic [10:0] sig4;
    logic [5:0]  e4;
    logic [3:0]  lz;
    logic [3:0]  sh;

    always_comb
    begin
        sig4 = st3_sum_reg[10:0];
        e4   = {1'b0, st3_el_reg};
        lz   = lzc11(st3_sum_reg[10:0]);
        sh   = '0;
        if (st3_special_reg)
        begin
            res = st3_special_val_reg;
        end
        else if (!st3_sub_reg)
        begin
            if (st3_sum_reg[11])
            begin
                sig4 = st3_sum_reg[11:1];
                e4   = e4 + 6'd1;
            end
            if (e4 >= {1'b0, ExpMax})
            begin
                res = {st3_sign_reg, HfPosInf[14:0]};
            end
            else if (sig4 < HfHidden)
            begin
                res = {st3_sign_reg, 5'd0, sig4[9:0]};
            end
            else
            begin
                res = {st3_sign_reg, e4[4:0], sig4[9:0]};
            end
        end
        else if (st3_eq_reg)
        begin
            res = '0;
        end
        else
        begin
            // Shift left by the leading zeros, but never below exponent 1.
            if ({2'b0, lz} > e4 - 6'd1)
            begin
                sh = 4'(e4 - 6'd1);
            end
            else
            begin
                sh = lz;
            end
            sig4 = st3_sum_reg[10:0] << sh;
            e4   = e4 - {2'b0, sh};
            if (sig4 < HfHidden)
            begin
                res = {st3_sign_reg, 5'd0, sig4[9:0]};
            end
            else
            begin
                res = {st3_sign_reg, e4[4:0], sig4[9:0]};
            end
        end
    end

    half_t out_reg;
    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            out_reg <= res;
        end
    end
    assign out_ch.data = out_reg;

    // A stalled result must hold until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("stalled sum word changed");

    // An accepted word reaches the last stage only by way of stage three.
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] && !$past(vld_reg[3]) |-> $past(vld_reg[2]))
        else $error("result appeared without passing stage three");

    // The input is never refused while the first stage is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[0] |-> in_ch.ready)
        else $error("empty pipeline refused a word");

endmodule
